FILE: rtl/buddy_page_allocator_top_defines.svh
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define BPA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bpa check failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bpa check failed");

`endif

FILE: rtl/bpa_pkg.sv
package bpa_pkg;

  localparam int NUM_PAGES  = 4096;
  localparam int PAGE_W     = 12;
  localparam int MAX_ORDERS = 13;
  localparam int ORD_W      = 4;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFREE = 2'd1,
    STAT_RANGE  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SPLIT,
    S_SPLIT_LO,
    S_SPLIT_HI,
    S_FREE_CHK,
    S_MERGE,
    S_MERGE_EVAL,
    S_UNLINK_RD,
    S_UNLINK_WR,
    S_PUSH,
    S_PUSH_LINK,
    S_PUSH_TAIL,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [ORD_W-1:0]   order;
    logic [PAGE_W-1:0]  page;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [PAGE_W-1:0]  block;
  } res_t;

endpackage

FILE: rtl/buddy_page_allocator_top.sv
// Buddy page allocator over 4096 pages, orders 0..12.
// Input items (s_axis): tuser = operation (0 allocate, 1 free),
//   tdata = order and page_index. One result item per input item on m_axis:
//   tuser = status, tdata = block_index.
// Config channel cfg_valid_i/cfg_ready_o/cfg_data_i writes top_order; write
//   it only while no item is in flight.
// One item at a time. A rejected item goes straight to its result; a free
//   steps through merge levels and an allocate through split levels, each
//   level a sequence of link and flag memory reads and writes.
// After reset a clearing pass over all 4096 pages wipes the listed flags;
//   no item is taken then. top_order resets to 13.
// The result sits in an output register; the next item is taken while it
//   waits, and the core holds its next result until the register frees.
module buddy_page_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [3:0] order, [15:4] page_index
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] block_index, [15:12] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);
  import bpa_pkg::*;

  logic [ORD_W-1:0] top_order_q, top_eff;
  logic             core_idle, res_valid, res_ready, in_acc;
  req_t             req;
  res_t             res, out_q;
  logic             out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) top_order_q <= ORD_W'(13);
    else if (cfg_valid_i) top_order_q <= cfg_data_i;
  end

  assign top_eff = (top_order_q < ORD_W'(MAX_ORDERS)) ? top_order_q : ORD_W'(MAX_ORDERS);

  assign s_axis_tready = core_idle;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign req.op        = op_e'(s_axis_tuser);
  assign req.order     = s_axis_tdata[3:0];
  assign req.page      = s_axis_tdata[15:4];

  bpa_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .top_i       (top_eff),
    .start_i     (in_acc),
    .req_i       (req),
    .idle_o      (core_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {4'b0, out_q.block};

`include "buddy_page_allocator_top_defines.svh"

  `BPA_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready)
  `BPA_ASSERT_NOW(a_fail_zero_block, m_axis_tvalid && m_axis_tuser != STAT_OK,
                  m_axis_tdata == 16'd0)
  `BPA_ASSERT_NOW(a_res_waits, res_valid && out_valid_q && !m_axis_tready, !res_ready)

endmodule

FILE: rtl/bpa_core.sv
module bpa_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [bpa_pkg::ORD_W-1:0] top_i,
  input  logic                    start_i,
  input  bpa_pkg::req_t           req_i,
  output logic                    idle_o,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output bpa_pkg::res_t           res_o
);
  import bpa_pkg::*;

  logic [PAGE_W-1:0] next_mem [NUM_PAGES];
  logic [PAGE_W-1:0] prev_mem [NUM_PAGES];
  logic [ORD_W:0]    meta_mem [NUM_PAGES];   // {listed, order}

  logic [PAGE_W-1:0] next_raddr, prev_raddr, meta_raddr;
  logic [PAGE_W-1:0] next_rd_q, prev_rd_q;
  logic [ORD_W:0]    meta_rd_q;
  logic              next_we, prev_we, meta_we;
  logic [PAGE_W-1:0] next_waddr, prev_waddr, meta_waddr;
  logic [PAGE_W-1:0] next_wdata, prev_wdata;
  logic [ORD_W:0]    meta_wdata;

  state_e state_q, state_d, ret_q, ret_d;
  logic [PAGE_W-1:0] head_q [MAX_ORDERS];
  logic [PAGE_W-1:0] head_d [MAX_ORDERS];
  logic [MAX_ORDERS-1:0] hvalid_q, hvalid_d;
  req_t              req_q, req_d;
  logic [PAGE_W-1:0] u_pg_q, u_pg_d, id_q, id_d, blk_q, blk_d, tail_q, tail_d;
  logic [ORD_W-1:0]  u_lv_q, u_lv_d, lv_q, lv_d;
  logic [PAGE_W-1:0] clr_q, clr_d;
  res_t              res_q, res_d;

  logic              found;
  logic [ORD_W-1:0]  found_lv;
  logic [PAGE_W-1:0] bud;

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    next_rd_q <= next_mem[next_raddr];
    prev_rd_q <= prev_mem[prev_raddr];
    meta_rd_q <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      ret_q    <= S_IDLE;
      hvalid_q <= '0;
      clr_q    <= '0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      hvalid_q <= hvalid_d;
      clr_q    <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    req_q  <= req_d;
    u_pg_q <= u_pg_d;
    u_lv_q <= u_lv_d;
    id_q   <= id_d;
    lv_q   <= lv_d;
    blk_q  <= blk_d;
    tail_q <= tail_d;
    res_q  <= res_d;
  end

  // lowest non-empty order in [order, top)
  always_comb begin
    found    = 1'b0;
    found_lv = '0;
    for (int i = MAX_ORDERS - 1; i >= 0; i--) begin
      if (ORD_W'(i) >= req_q.order && ORD_W'(i) < top_i && hvalid_q[i]) begin
        found    = 1'b1;
        found_lv = ORD_W'(i);
      end
    end
  end

  assign bud = id_q ^ (PAGE_W'(1) << lv_q);

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    head_d  = head_q;
    hvalid_d = hvalid_q;
    req_d   = req_q;
    u_pg_d  = u_pg_q;
    u_lv_d  = u_lv_q;
    id_d    = id_q;
    lv_d    = lv_q;
    blk_d   = blk_q;
    tail_d  = tail_q;
    clr_d   = clr_q;
    res_d   = res_q;
    next_raddr = u_pg_q;
    prev_raddr = u_pg_q;
    meta_raddr = req_q.page;
    next_we = 1'b0;  next_waddr = u_pg_q;  next_wdata = u_pg_q;
    prev_we = 1'b0;  prev_waddr = u_pg_q;  prev_wdata = u_pg_q;
    meta_we = 1'b0;  meta_waddr = u_pg_q;  meta_wdata = {1'b1, u_lv_q};

    case (state_q)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_q;
        meta_wdata = '0;
        clr_d      = clr_q + PAGE_W'(1);
        if (clr_q == PAGE_W'(NUM_PAGES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_d.block = '0;
        res_d.status = STAT_OK;
        if (req_q.order >= top_i) begin
          res_d.status = STAT_RANGE;
          state_d = S_DONE;
        end else if (req_q.op == OP_ALLOC) begin
          if (!found) begin
            res_d.status = STAT_NOFREE;
            state_d = S_DONE;
          end else begin
            lv_d    = found_lv;
            state_d = S_SPLIT;
          end
        end else begin
          state_d = S_FREE_CHK;   // meta of page is being read
        end
      end
      S_SPLIT: begin
        u_pg_d  = head_q[lv_q];
        u_lv_d  = lv_q;
        blk_d   = head_q[lv_q];
        state_d = S_UNLINK_RD;
        if (lv_q > req_q.order) begin
          ret_d = S_SPLIT_LO;
        end else begin
          res_d.block = head_q[lv_q];
          ret_d = S_DONE;
        end
      end
      S_SPLIT_LO: begin
        lv_d    = lv_q - ORD_W'(1);
        u_pg_d  = blk_q;
        u_lv_d  = lv_q - ORD_W'(1);
        ret_d   = S_SPLIT_HI;
        state_d = S_PUSH;
      end
      S_SPLIT_HI: begin
        // buddy always inside the page range
        u_pg_d  = blk_q ^ (PAGE_W'(1) << lv_q);
        u_lv_d  = lv_q;
        ret_d   = S_SPLIT;
        state_d = S_PUSH;
      end
      S_FREE_CHK: begin
        if (meta_rd_q[ORD_W]) begin
          state_d = S_DONE;       // double free
        end else begin
          id_d    = req_q.page;
          lv_d    = req_q.order;
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        meta_raddr = bud;
        if ({1'b0, lv_q} + 5'd1 < {1'b0, top_i}) begin
          state_d = S_MERGE_EVAL;
        end else begin
          u_pg_d  = id_q;
          u_lv_d  = lv_q;
          ret_d   = S_DONE;
          state_d = S_PUSH;
        end
      end
      S_MERGE_EVAL: begin
        if (meta_rd_q == {1'b1, lv_q}) begin
          u_pg_d  = bud;
          u_lv_d  = lv_q;
          id_d    = (bud < id_q) ? bud : id_q;
          lv_d    = lv_q + ORD_W'(1);
          ret_d   = S_MERGE;
          state_d = S_UNLINK_RD;
        end else begin
          u_pg_d  = id_q;
          u_lv_d  = lv_q;
          ret_d   = S_DONE;
          state_d = S_PUSH;
        end
      end
      S_UNLINK_RD: begin
        state_d = S_UNLINK_WR;
      end
      S_UNLINK_WR: begin
        meta_we    = 1'b1;
        meta_wdata = {1'b0, u_lv_q};
        if (prev_rd_q == u_pg_q) begin
          hvalid_d[u_lv_q] = 1'b0;
          head_d[u_lv_q]   = '0;
        end else begin
          if (head_q[u_lv_q] == u_pg_q) head_d[u_lv_q] = next_rd_q;
          prev_we    = 1'b1;
          prev_waddr = next_rd_q;
          prev_wdata = prev_rd_q;
          next_we    = 1'b1;
          next_waddr = prev_rd_q;
          next_wdata = next_rd_q;
        end
        state_d = ret_q;
      end
      S_PUSH: begin
        meta_we    = 1'b1;
        prev_raddr = head_q[u_lv_q];
        if (!hvalid_q[u_lv_q]) begin
          hvalid_d[u_lv_q] = 1'b1;
          head_d[u_lv_q]   = u_pg_q;
          next_we = 1'b1;
          prev_we = 1'b1;
          state_d = ret_q;
        end else begin
          state_d = S_PUSH_LINK;
        end
      end
      S_PUSH_LINK: begin
        tail_d     = prev_rd_q;
        next_we    = 1'b1;
        next_wdata = head_q[u_lv_q];
        prev_we    = 1'b1;
        prev_wdata = prev_rd_q;
        state_d    = S_PUSH_TAIL;
      end
      S_PUSH_TAIL: begin
        next_we    = 1'b1;
        next_waddr = tail_q;
        prev_we    = 1'b1;
        prev_waddr = head_q[u_lv_q];
        state_d    = ret_q;
      end
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule
